>>> hdl/ook_pulse_width_frame_decoder_assert.svh
// ----------------------------------------------------------------------------
// OOK decoder assertion macros
// Shared property forms for the decoder checks; clock and reset are the
// top-level i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef OOK_PULSE_WIDTH_FRAME_DECODER_ASSERT_SVH
`define OOK_PULSE_WIDTH_FRAME_DECODER_ASSERT_SVH

// same-cycle implication
`define OOK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OOK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ook_pkg.sv
// ----------------------------------------------------------------------------
// OOK decoder package
// Sizes, constants, payload types and state encodings shared by the decoder.
// ----------------------------------------------------------------------------
package ook_pkg;

    localparam int MAX_PULSES = 512;
    localparam int FRAME_BITS = 24;

    localparam int DUR_W    = 16;
    localparam int CODE_W   = 24;
    localparam int BITCNT_W = 5;
    localparam int FLOOR_W  = 16;
    localparam int MINP_W   = 10;

    localparam int CNT_W     = $clog2(MAX_PULSES + 1);
    localparam int IDX_W     = $clog2(MAX_PULSES);
    localparam int IDXC_W    = $clog2(MAX_PULSES + 3);
    localparam int CMP_W     = (CNT_W > MINP_W) ? CNT_W : MINP_W;
    localparam int BITS_W    = $clog2(FRAME_BITS + 1);
    localparam int BANKS     = 2;
    localparam int RAM_DEPTH = BANKS * MAX_PULSES;

    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    // band limits in tenths of a unit; compared against ten times a duration
    localparam int SHORT_LO_NUM = 6;
    localparam int SHORT_HI_NUM = 16;
    localparam int LONG_LO_NUM  = 22;
    localparam int LONG_HI_NUM  = 45;
    localparam int RATIO_DEN    = 10;
    localparam int SYNC_UNITS   = 10;
    localparam int BND_W        = DUR_W + 6;
    localparam int MUL10_W      = DUR_W + 4;

    localparam logic [FLOOR_W-1:0] GLITCH_FLOOR_RST = FLOOR_W'(80);
    localparam logic [MINP_W-1:0]  MIN_PULSES_RST   = MINP_W'(40);

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_SEL_BIT = 2;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic             last;
    } t_in;

    typedef struct packed {
        logic                frame_valid;
        logic [CODE_W-1:0]   code;
        logic [BITCNT_W-1:0] bit_count;
        logic [DUR_W-1:0]    pulse_unit;
    } t_out;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] n;
        logic [DUR_W-1:0] te;
        logic             skip;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SETUP,
        B_SYNC_RD,
        B_SYNC_CHK,
        B_MK_RD,
        B_SP_RD,
        B_PAIR,
        B_OUT
    } t_back_state;

    typedef enum logic {
        REG_GLITCH_FLOOR = 1'b0,
        REG_MIN_PULSES   = 1'b1
    } t_reg_idx;

endpackage

>>> hdl/ook_ram.sv
// ----------------------------------------------------------------------------
// OOK generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ook_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/ook_front.sv
// ----------------------------------------------------------------------------
// OOK capture front end
// Stores durations into the active bank, tracks the shortest real pulse and
// queues a decode job when the last duration arrives.
// ----------------------------------------------------------------------------
module ook_front import ook_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  t_in                            i_in_data,
    input  logic [FLOOR_W-1:0]             i_glitch_floor,
    input  logic [MINP_W-1:0]              i_min_pulses,
    input  logic                           i_job_done,
    output logic                           o_we,
    output logic [$clog2(RAM_DEPTH)-1:0]   o_waddr,
    output logic [DUR_W-1:0]               o_wdata,
    output logic                           o_push,
    output t_job                           o_job
);

    logic [CNT_W-1:0]     r_count;
    logic [DUR_W-1:0]     r_shortest;
    logic                 r_found;
    logic                 r_bank;
    logic [JOB_CNT_W-1:0] r_outst;

    logic [CNT_W-1:0]     n_count;
    logic [DUR_W-1:0]     n_shortest;
    logic                 n_found;
    logic                 w_accept;
    logic                 w_store;
    logic                 w_take;

    // a bank is free while fewer captures than banks are still in flight
    assign o_in_ready = (r_outst < JOB_CNT_W'(BANKS));
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_store    = (r_count < CNT_W'(MAX_PULSES));
    assign w_take     = w_store && (i_in_data.duration >= i_glitch_floor) &&
                        (!r_found || (i_in_data.duration < r_shortest));

    always_comb begin
        n_count    = w_store ? r_count + CNT_W'(1) : r_count;
        n_shortest = w_take ? i_in_data.duration : r_shortest;
        n_found    = r_found || w_take;
    end

    assign o_we    = w_accept && w_store;
    assign o_waddr = {r_bank, r_count[IDX_W-1:0]};
    assign o_wdata = i_in_data.duration;
    assign o_push  = w_accept && i_in_data.last;

    always_comb begin
        o_job.bank = r_bank;
        o_job.n    = n_count;
        o_job.te   = n_shortest;
        o_job.skip = (CMP_W'(n_count) < CMP_W'(i_min_pulses)) || !n_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_shortest <= '1;
            r_found    <= 1'b0;
            r_bank     <= 1'b0;
        end else if (w_accept) begin
            if (i_in_data.last) begin
                r_count    <= '0;
                r_shortest <= '1;
                r_found    <= 1'b0;
                r_bank     <= !r_bank;
            end else begin
                r_count    <= n_count;
                r_shortest <= n_shortest;
                r_found    <= n_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else begin
            case ({o_push, i_job_done})
                2'b10:   r_outst <= r_outst + JOB_CNT_W'(1);
                2'b01:   r_outst <= r_outst - JOB_CNT_W'(1);
                default: r_outst <= r_outst;
            endcase
        end
    end

endmodule

>>> hdl/ook_job_fifo.sv
// ----------------------------------------------------------------------------
// OOK decode job queue
// Short first-in first-out queue of decode jobs between front and back end.
// ----------------------------------------------------------------------------
module ook_job_fifo import ook_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_job       i_job,
    input  logic       i_pop,
    output t_job       o_job,
    output t_fifo_stat o_stat
);

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wptr;
    logic [JOB_PTR_W-1:0] r_rptr;
    logic [JOB_CNT_W-1:0] r_cnt;

    assign o_job        = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == JOB_CNT_W'(JOB_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + JOB_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + JOB_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + JOB_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - JOB_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> hdl/ook_back.sv
// ----------------------------------------------------------------------------
// OOK frame decode back end
// Walks one stored capture: finds the sync space, then classifies mark/space
// pairs into code bits and presents the result.
// ----------------------------------------------------------------------------
module ook_back import ook_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_job                         i_job,
    input  t_fifo_stat                   i_stat,
    output logic                         o_pop,
    output logic                         o_re,
    output logic [$clog2(RAM_DEPTH)-1:0] o_raddr,
    input  logic [DUR_W-1:0]             i_rdata,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output t_out                         o_out_data,
    output logic                         o_done
);

    t_back_state           r_state;
    t_back_state           n_state;
    t_job                  r_job;
    logic [BND_W-1:0]      r_s_lo;
    logic [BND_W-1:0]      r_s_hi;
    logic [BND_W-1:0]      r_l_lo;
    logic [BND_W-1:0]      r_l_hi;
    logic [MUL10_W-1:0]    r_sync;
    logic [IDXC_W-1:0]     r_idx;
    logic [DUR_W-1:0]      r_mark;
    logic [FRAME_BITS-1:0] r_code;
    logic [BITS_W-1:0]     r_bits;

    logic [IDXC_W-1:0]     w_idx1;
    logic                  w_idx_in;
    logic                  w_pair_in;
    logic                  w_more_bits;
    logic                  w_sync_hit;
    logic [BND_W-1:0]      w_mk10;
    logic [BND_W-1:0]      w_sp10;
    logic                  w_mk_short;
    logic                  w_mk_long;
    logic                  w_sp_short;
    logic                  w_sp_long;
    logic                  w_bit0;
    logic                  w_bit1;
    logic                  w_full;

    assign w_idx1      = r_idx + IDXC_W'(1);
    assign w_idx_in    = (r_idx < IDXC_W'(r_job.n));
    assign w_pair_in   = (w_idx1 < IDXC_W'(r_job.n));
    assign w_more_bits = (r_bits < BITS_W'(FRAME_BITS));
    assign w_full      = (r_bits == BITS_W'(FRAME_BITS));
    assign w_sync_hit  = (MUL10_W'(i_rdata) >= r_sync);

    // ten times each duration, so truncated band limits compare exactly
    assign w_mk10 = BND_W'({r_mark, 3'b000}) + BND_W'({r_mark, 1'b0});
    assign w_sp10 = BND_W'({i_rdata, 3'b000}) + BND_W'({i_rdata, 1'b0});

    assign w_mk_short = (r_s_lo <= w_mk10 + BND_W'(RATIO_DEN - 1)) && (w_mk10 <= r_s_hi);
    assign w_mk_long  = (r_l_lo <= w_mk10 + BND_W'(RATIO_DEN - 1)) && (w_mk10 <= r_l_hi);
    assign w_sp_short = (r_s_lo <= w_sp10 + BND_W'(RATIO_DEN - 1)) && (w_sp10 <= r_s_hi);
    assign w_sp_long  = (r_l_lo <= w_sp10 + BND_W'(RATIO_DEN - 1)) && (w_sp10 <= r_l_hi);
    assign w_bit0     = w_mk_short && w_sp_long;
    assign w_bit1     = !w_bit0 && w_mk_long && w_sp_short;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_stat.empty) begin
                    n_state = B_SETUP;
                end
            end
            B_SETUP: begin
                n_state = r_job.skip ? B_OUT : B_SYNC_RD;
            end
            B_SYNC_RD: begin
                n_state = w_idx_in ? B_SYNC_CHK : B_OUT;
            end
            B_SYNC_CHK: begin
                n_state = w_sync_hit ? B_MK_RD : B_SYNC_RD;
            end
            B_MK_RD: begin
                n_state = (w_more_bits && w_pair_in) ? B_SP_RD : B_OUT;
            end
            B_SP_RD: begin
                n_state = B_PAIR;
            end
            B_PAIR: begin
                n_state = (w_bit0 || w_bit1) ? B_MK_RD : B_OUT;
            end
            B_OUT: begin
                if (i_out_ready) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        o_re        = 1'b0;
        o_raddr     = {r_job.bank, r_idx[IDX_W-1:0]};
        o_out_valid = 1'b0;
        o_done      = 1'b0;
        case (r_state)
            B_IDLE: begin
                o_pop = !i_stat.empty;
            end
            B_SYNC_RD: begin
                o_re = w_idx_in;
            end
            B_MK_RD: begin
                o_re = w_more_bits && w_pair_in;
            end
            B_SP_RD: begin
                o_re    = 1'b1;
                o_raddr = {r_job.bank, w_idx1[IDX_W-1:0]};
            end
            B_OUT: begin
                o_out_valid = 1'b1;
                o_done      = i_out_ready;
            end
            default: begin
                o_re = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_out_data.frame_valid = w_full;
        o_out_data.code        = w_full ? CODE_W'(r_code) : '0;
        o_out_data.bit_count   = w_full ? BITCNT_W'(FRAME_BITS) : '0;
        o_out_data.pulse_unit  = r_job.skip ? '0 : r_job.te;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (!i_stat.empty) begin
                    r_job  <= i_job;
                    r_idx  <= IDXC_W'(1);
                    r_bits <= '0;
                    r_code <= '0;
                end
            end
            B_SETUP: begin
                r_s_lo <= BND_W'(r_job.te) * BND_W'(SHORT_LO_NUM);
                r_s_hi <= BND_W'(r_job.te) * BND_W'(SHORT_HI_NUM);
                r_l_lo <= BND_W'(r_job.te) * BND_W'(LONG_LO_NUM);
                r_l_hi <= BND_W'(r_job.te) * BND_W'(LONG_HI_NUM);
                r_sync <= MUL10_W'(r_job.te) * MUL10_W'(SYNC_UNITS);
            end
            B_SYNC_CHK: begin
                r_idx <= w_sync_hit ? w_idx1 : r_idx + IDXC_W'(2);
            end
            B_SP_RD: begin
                r_mark <= i_rdata;
            end
            B_PAIR: begin
                if (w_bit0 || w_bit1) begin
                    r_code <= {r_code[FRAME_BITS-2:0], w_bit1};
                    r_bits <= r_bits + BITS_W'(1);
                    r_idx  <= r_idx + IDXC_W'(2);
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

endmodule

>>> hdl/ook_pulse_width_frame_decoder.sv
// ----------------------------------------------------------------------------
// OOK pulse-width frame decoder
// Throughput: one duration per cycle while a bank is free; the walk over
//   the stored capture (one RAM read port) sets the decode time.
// Reset: synchronous, active low; registers return to 80 and 40, the
//   capture store is not cleared.
// ----------------------------------------------------------------------------
`include "ook_pulse_width_frame_decoder_assert.svh"

module ook_pulse_width_frame_decoder import ook_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // capture input
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in                i_in_data,
    // decode result
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out               o_out_data,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Two capture banks live in one RAM. The front end fills one bank while
    // the back end decodes the other; jobs pass through a two-entry queue.

    localparam int RAM_AW = $clog2(RAM_DEPTH);

    logic [FLOOR_W-1:0] r_glitch_floor;
    logic [MINP_W-1:0]  r_min_pulses;

    logic               w_cfg_wr;
    t_reg_idx           w_reg_idx;

    logic               w_we;
    logic [RAM_AW-1:0]  w_waddr;
    logic [DUR_W-1:0]   w_wdata;
    logic               w_re;
    logic [RAM_AW-1:0]  w_raddr;
    logic [DUR_W-1:0]   w_rdata;

    logic               w_push;
    t_job               w_push_job;
    logic               w_pop;
    t_job               w_head_job;
    t_fifo_stat         w_fifo_stat;
    logic               w_job_done;

    logic               w_res_take;
    logic               w_res_void;
    logic               w_res_blank;

    // ------------------------------------------------------------------
    // Configuration registers: write on the access phase, pready tied high
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[REG_SEL_BIT]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glitch_floor <= GLITCH_FLOOR_RST;
            r_min_pulses   <= MIN_PULSES_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_GLITCH_FLOOR: r_glitch_floor <= pwdata[FLOOR_W-1:0];
                REG_MIN_PULSES:   r_min_pulses   <= pwdata[MINP_W-1:0];
                default:          r_glitch_floor <= r_glitch_floor;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_GLITCH_FLOOR: prdata = PDATA_W'(r_glitch_floor);
            REG_MIN_PULSES:   prdata = PDATA_W'(r_min_pulses);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front end: store durations, track the unit, queue the job
    // ------------------------------------------------------------------
    ook_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .i_glitch_floor (r_glitch_floor),
        .i_min_pulses   (r_min_pulses),
        .i_job_done     (w_job_done),
        .o_we           (w_we),
        .o_waddr        (w_waddr),
        .o_wdata        (w_wdata),
        .o_push         (w_push),
        .o_job          (w_push_job)
    );

    // Capture store, both banks
    ook_ram #(
        .WIDTH (DUR_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Job queue decouples capture from decode
    ook_job_fifo u_jobs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_fifo_stat)
    );

    // ------------------------------------------------------------------
    // Back end: sync search, pair decode, hold result until taken
    // ------------------------------------------------------------------
    ook_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_head_job),
        .i_stat      (w_fifo_stat),
        .o_pop       (w_pop),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_done      (w_job_done)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    assign w_res_take  = o_out_valid && i_out_ready;
    assign w_res_void  = o_out_valid && !o_out_data.frame_valid;
    assign w_res_blank = (o_out_data.code == '0) && (o_out_data.bit_count == '0);

    `OOK_ASSERT_IMP(a_invalid_zero, w_res_void, w_res_blank, "invalid frame not zeroed")
    `OOK_ASSERT_IMP(a_queue_room, w_push, !w_fifo_stat.full, "job pushed into full queue")
    `OOK_ASSERT_NXT(a_single_result, w_res_take, !o_out_valid, "result presented twice")

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// OOK pulse-width frame decoder testbench
// Feeds mark/space captures through the request channel, predicts each
// decode result with a local model of the capture store and the frame walk,
// and checks every result in order. A short directed table covers the
// register extremes and the corner cases of the decode. A random part
// follows, built mostly from well-formed frames with random timing, plus
// broken, truncated, noisy and store-overflowing captures. Both channels
// idle at random, and the receiver holds off once to back up the block.
// ----------------------------------------------------------------------------
module tb_top;
    import ook_pkg::*;

    localparam int TIMEOUT_CYCLES = 800000;
    localparam int SETTLE_CYCLES  = 64;     // well above the per-item load time
    localparam int RX_HOLD_CYCLES = 3000;
    localparam int MAX_REPORTS    = 10;
    localparam int ITEM_TARGET    = 1250;
    localparam int RESULT_TARGET  = 20;
    localparam int DIR_ROW_COUNT  = 30;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef enum {
        CAP_FRAME,
        CAP_BROKEN,
        CAP_TRUNC,
        CAP_NOISE,
        CAP_LONG
    } t_cap_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_reg_idx          reg_sel;
        logic [PDATA_W-1:0] value;
        t_in               item;
        logic              typed;
        t_out              want;
    } t_dir_row;

    // Directed table. Rows with typed set carry a result read straight off
    // the decode rules; all other results come from the predictor.
    localparam t_dir_row DIR_ROWS [DIR_ROW_COUNT] = '{
        // too short right after reset: one duration against min 40
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'hFFFF, 1'b1}, 1'b1, '0},
        '{ROW_CFG,  REG_MIN_PULSES,   32'd0, '{16'd0, 1'b0}, 1'b0, '0},
        // nothing reaches the floor
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd0, 1'b1}, 1'b1, '0},
        // exactly on the floor, no sync space
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd80, 1'b1}, 1'b1,
          '{1'b0, 24'd0, 5'd0, 16'd80}},
        '{ROW_CFG,  REG_GLITCH_FLOOR, 32'd0, '{16'd0, 1'b0}, 1'b0, '0},
        // zero floor, zero unit
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd0, 1'b1}, 1'b1, '0},
        '{ROW_CFG,  REG_GLITCH_FLOOR, 32'd65535, '{16'd0, 1'b0}, 1'b0, '0},
        // top floor: only the top duration counts
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd65534, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd65535, 1'b1}, 1'b1,
          '{1'b0, 24'd0, 5'd0, 16'd65535}},
        '{ROW_CFG,  REG_GLITCH_FLOOR, 32'd80, '{16'd0, 1'b0}, 1'b0, '0},
        // floor raised in the middle of a capture
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd100, 1'b0}, 1'b0, '0},
        '{ROW_CFG,  REG_GLITCH_FLOOR, 32'd200, '{16'd0, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd150, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd300, 1'b1}, 1'b0, '0},
        '{ROW_CFG,  REG_GLITCH_FLOOR, 32'd80, '{16'd0, 1'b0}, 1'b0, '0},
        // min above the store size
        '{ROW_CFG,  REG_MIN_PULSES,   32'd1023, '{16'd0, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd500, 1'b1}, 1'b1, '0},
        '{ROW_CFG,  REG_MIN_PULSES,   32'd0, '{16'd0, 1'b0}, 1'b0, '0},
        // sync, three good pairs, then the capture runs out
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd100, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd1000, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd100, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd300, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd300, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd100, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd100, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd300, 1'b1}, 1'b0, '0},
        // sync followed by a pair that fits neither band
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd100, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd2000, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd200, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, REG_GLITCH_FLOOR, 32'd0, '{16'd200, 1'b1}, 1'b0, '0}
    };

    // DUT signals, every input driven to a known value from time zero
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    t_in                i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out               o_out_data;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // decoder model state: capture store plus register copies
    logic [DUR_W-1:0]   cap_store [MAX_PULSES];
    int unsigned        cap_count    = 0;
    logic [DUR_W-1:0]   cap_shortest = '1;
    bit                 cap_found    = 1'b0;
    logic [FLOOR_W-1:0] cfg_floor    = GLITCH_FLOOR_RST;
    logic [MINP_W-1:0]  cfg_min      = MIN_PULSES_RST;

    t_out        pending_frames [$];
    int unsigned mismatches       = 0;
    int unsigned items_accepted   = 0;
    int unsigned frames_predicted = 0;

    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;
    bit rx_hold_req = 1'b0;

    ook_pulse_width_frame_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_CYCLES * 20);
        $display("status: fail");
        $finish;
    end

    function automatic bit in_band(input int unsigned v, input int unsigned lo,
                                   input int unsigned hi);
        return v >= lo && v <= hi;
    endfunction

    // Store one duration, and on the last one walk the capture:
    // unit estimate, sync search, then up to FRAME_BITS mark/space pairs.
    function automatic bit ook_decode_step(input t_in item, output t_out res);
        int unsigned n, te, s_lo, s_hi, l_lo, l_hi, sync_min, idx, nbits, mk, sp;
        logic [31:0] acc;
        bit          synced, pair_ok;
        res     = '0;
        acc     = '0;
        nbits   = 0;
        pair_ok = 1'b1;
        if (cap_count < MAX_PULSES) begin
            cap_store[cap_count] = item.duration;
            cap_count++;
            if (item.duration >= cfg_floor && (!cap_found || item.duration < cap_shortest)) begin
                cap_shortest = item.duration;
                cap_found    = 1'b1;
            end
        end
        if (!item.last)
            return 1'b0;
        n = cap_count;
        if (n >= cfg_min && cap_found) begin
            te             = cap_shortest;
            res.pulse_unit = cap_shortest;
            s_lo     = te * 6 / 10;
            s_hi     = te * 16 / 10;
            l_lo     = te * 22 / 10;
            l_hi     = te * 45 / 10;
            sync_min = te * 10;
            // sync search runs over spaces only
            idx = 1;
            while (idx < n && cap_store[idx] < sync_min)
                idx += 2;
            synced = idx < n;
            if (synced) begin
                idx++;
                while (pair_ok && nbits < FRAME_BITS && idx + 1 < n) begin
                    mk = cap_store[idx];
                    sp = cap_store[idx + 1];
                    idx += 2;
                    if (in_band(mk, s_lo, s_hi) && in_band(sp, l_lo, l_hi)) begin
                        acc = {acc[30:0], 1'b0};
                        nbits++;
                    end else if (in_band(mk, l_lo, l_hi) && in_band(sp, s_lo, s_hi)) begin
                        acc = {acc[30:0], 1'b1};
                        nbits++;
                    end else begin
                        pair_ok = 1'b0;
                    end
                end
            end
            if (synced && nbits >= FRAME_BITS) begin
                res.frame_valid = 1'b1;
                res.code        = acc[CODE_W-1:0];
                res.bit_count   = BITCNT_W'(FRAME_BITS);
            end
        end
        cap_count    = 0;
        cap_shortest = '1;
        cap_found    = 1'b0;
        return 1'b1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [DUR_W-1:0] noise_duration();
        case ($urandom_range(0, 2))
            0: return DUR_W'($urandom_range(0, 65535));
            1: return DUR_W'($urandom_range(0, 400));
            default: return DUR_W'($urandom_range(100, 4000));
        endcase
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Offer one request; keep valid high across back-to-back requests and
    // only drop it when a gap is drawn.
    task automatic push_request(input t_in item, input bit typed, input t_out typed_want);
        t_out        res;
        int unsigned gap;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        items_accepted++;
        if (ook_decode_step(item, res)) begin
            pending_frames.push_back(typed ? typed_want : res);
            frames_predicted++;
        end
    endtask

    // Drop the request line, wait for every pending result, then let the
    // block finish loading before anything else happens.
    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write a register, then read it back in the next transfer.
    task automatic set_register(input t_reg_idx sel, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(sel) << REG_SEL_BIT;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (sel == REG_GLITCH_FLOOR) begin
            cfg_floor = value[FLOOR_W-1:0];
            want      = PDATA_W'(value[FLOOR_W-1:0]);
        end else begin
            cfg_min = value[MINP_W-1:0];
            want    = PDATA_W'(value[MINP_W-1:0]);
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata !== want)
            flag_error($sformatf("register %s readback: want %08h got %08h",
                                 sel.name(), want, prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Build one capture of the given shape and send it, last on the final
    // duration. Frame timing keeps every short within 1.0..1.2 units and
    // every long within 2.8..3.5 units of the chosen unit, so a clean frame
    // decodes whatever short ends up as the estimate.
    task automatic run_capture(input t_cap_kind kind);
        logic [DUR_W-1:0] durs [$];
        int unsigned      te, pairs, total, pos;
        t_in              item;
        t_out             unused_want;
        unused_want = '0;
        if (kind == CAP_NOISE) begin
            total = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(13, 90);
            repeat (total) durs.push_back(noise_duration());
        end else begin
            if (cfg_floor > 3000 || cfg_floor < 100)
                te = $urandom_range(100, 3000);
            else
                te = $urandom_range(cfg_floor, 3000);
            // preamble pairs with spaces well short of sync
            repeat ($urandom_range(0, 3)) begin
                durs.push_back(DUR_W'($urandom_range(te, 3 * te)));
                durs.push_back(DUR_W'($urandom_range(2 * te, 8 * te)));
            end
            durs.push_back(DUR_W'($urandom_range(te, te * 12 / 10)));
            durs.push_back(DUR_W'($urandom_range(te * 13, te * 20)));
            pairs = (kind == CAP_TRUNC) ? $urandom_range(0, FRAME_BITS - 1) : FRAME_BITS;
            repeat (pairs) begin
                if ($urandom_range(0, 1) == 1) begin
                    durs.push_back(DUR_W'($urandom_range(te * 28 / 10, te * 35 / 10)));
                    durs.push_back(DUR_W'($urandom_range(te, te * 12 / 10)));
                end else begin
                    durs.push_back(DUR_W'($urandom_range(te, te * 12 / 10)));
                    durs.push_back(DUR_W'($urandom_range(te * 28 / 10, te * 35 / 10)));
                end
            end
            repeat ($urandom_range(0, 3)) durs.push_back(DUR_W'($urandom_range(te, 3 * te)));
            if (kind == CAP_BROKEN)
                durs[$urandom_range(0, durs.size() - 1)] = noise_duration();
            // overflow the store with trailing noise
            if (kind == CAP_LONG) begin
                total = $urandom_range(MAX_PULSES + 1, MAX_PULSES + 88);
                while (durs.size() < total)
                    durs.push_back(noise_duration());
            end
        end
        for (pos = 0; pos < durs.size(); pos++) begin
            item.duration = durs[pos];
            item.last     = (pos == durs.size() - 1);
            push_request(item, 1'b0, unused_want);
        end
    endtask

    // Result side: draw stall lengths at random, or hold off for a long
    // stretch when asked so the block backs up into its input.
    initial begin : result_ready
        int unsigned stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end else if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 2) == 0)
                    stall = pick_gap();
            end
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_frames.size() == 0) begin
                flag_error($sformatf("result with none pending: valid=%0d code=%06h bits=%0d unit=%0d",
                                     o_out_data.frame_valid, o_out_data.code,
                                     o_out_data.bit_count, o_out_data.pulse_unit));
            end else begin
                want = pending_frames.pop_front();
                if (o_out_data.frame_valid !== want.frame_valid ||
                    o_out_data.code !== want.code ||
                    o_out_data.bit_count !== want.bit_count ||
                    o_out_data.pulse_unit !== want.pulse_unit) begin
                    flag_error($sformatf({"frame mismatch: want valid=%0d code=%06h bits=%0d ",
                                          "unit=%0d, got valid=%0d code=%06h bits=%0d unit=%0d"},
                                         want.frame_valid, want.code, want.bit_count,
                                         want.pulse_unit, o_out_data.frame_valid,
                                         o_out_data.code, o_out_data.bit_count,
                                         o_out_data.pulse_unit));
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned        r, phase, cap_idx;
        logic [PDATA_W-1:0] word;
        logic [FLOOR_W-1:0] floor_val;
        logic [MINP_W-1:0]  min_val;
        t_cap_kind          kind;
        t_dir_row           row;

        // hold reset, then release it on a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // directed table
        for (int k = 0; k < DIR_ROW_COUNT; k++) begin
            row = DIR_ROWS[k];
            if (row.kind == ROW_CFG) begin
                settle_block();
                set_register(row.reg_sel, row.value);
            end else begin
                push_request(row.item, row.typed, row.want);
            end
        end

        // random phases: a fresh register setting each phase, extremes
        // included, then a handful of captures
        phase   = 0;
        cap_idx = 0;
        while (items_accepted < ITEM_TARGET || frames_predicted < RESULT_TARGET) begin
            settle_block();
            case (phase % 6)
                0: floor_val = GLITCH_FLOOR_RST;
                1: floor_val = '0;
                2: floor_val = FLOOR_W'($urandom_range(0, 400));
                3: floor_val = '1;
                4: floor_val = FLOOR_W'($urandom_range(0, 150));
                default: floor_val = FLOOR_W'($urandom_range(0, 65535));
            endcase
            case (phase % 5)
                0: min_val = MIN_PULSES_RST;
                1: min_val = '0;
                2: min_val = MINP_W'($urandom_range(0, 60));
                3: min_val = MINP_W'(MAX_PULSES);
                default: min_val = '1;
            endcase
            // junk in the unused upper bits of the write data
            word = $urandom();
            word[FLOOR_W-1:0] = floor_val;
            set_register(REG_GLITCH_FLOOR, word);
            word = $urandom();
            word[MINP_W-1:0] = min_val;
            set_register(REG_MIN_PULSES, word);

            @(posedge i_clk);
            tx_steady = (phase % 4 == 1);
            rx_steady = (phase % 4 == 3);
            if (phase == 2)
                rx_hold_req = 1'b1;

            // stop at the capture that reaches the targets
            for (int c = 0; c < 5 && (items_accepted < ITEM_TARGET ||
                                      frames_predicted < RESULT_TARGET); c++) begin
                r = $urandom_range(0, 99);
                if (cap_idx % 20 == 16)
                    kind = CAP_LONG;
                else if (r < 55)
                    kind = CAP_FRAME;
                else if (r < 67)
                    kind = CAP_BROKEN;
                else if (r < 77)
                    kind = CAP_TRUNC;
                else
                    kind = CAP_NOISE;
                run_capture(kind);
                cap_idx++;
            end
            phase++;
        end

        settle_block();
        if (mismatches == 0 && pending_frames.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
